// ----- rtl/core/ipr_pkg.sv -----
// ----------------------------------------------------------------------------
// ipr_pkg
// Shared types and constants for the IPv4 range area classifier.
// ----------------------------------------------------------------------------
package ipr_pkg;

  localparam int ADDR_W        = 32;
  localparam int AREA_PORT_W   = 8;
  localparam int ENTRIES_DEF   = 64;
  localparam int AREA_BITS_DEF = 8;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_LOCATE = 2'd1,
    REQ_CHECK  = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] high;
  } bounds_t;

endpackage

// ----- rtl/core/ipr_table.sv -----
// ----------------------------------------------------------------------------
// ipr_table
// Range table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ipr_table import ipr_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int AREA_BITS = AREA_BITS_DEF,
  parameter int IW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_addr,
  input  bounds_t              wr_bounds,
  input  logic [AREA_BITS-1:0] wr_area,
  input  logic                 rd_en,
  input  logic [IW-1:0]        rd_addr,
  output bounds_t              rd_bounds,
  output logic [AREA_BITS-1:0] rd_area
);

  bounds_t              bounds_mem [ENTRIES];
  logic [AREA_BITS-1:0] area_mem   [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bounds_mem[wr_addr] <= wr_bounds;
      area_mem[wr_addr]   <= wr_area;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bounds <= bounds_mem[rd_addr];
      rd_area   <= area_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/ipr_scan.sv -----
// ----------------------------------------------------------------------------
// ipr_scan
// Shared compare unit: tests one table entry per cycle while en is high and accumulates.
// ----------------------------------------------------------------------------
module ipr_scan import ipr_pkg::*; #(
  parameter int AREA_BITS = AREA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 en,
  input  logic                 locate,
  input  logic [ADDR_W-1:0]    addr,
  input  logic [AREA_BITS-1:0] req_area,
  input  bounds_t              bounds,
  input  logic [AREA_BITS-1:0] area,
  output logic                 hit,
  output logic [AREA_BITS-1:0] found
);

  logic holds;
  logic take;

  assign holds = (addr >= bounds.low) && (addr <= bounds.high);

  // locate keeps the smallest area; check only needs one area match
  always_comb begin
    if (locate) begin
      take = holds && (!hit || (area < found));
    end else begin
      take = holds && (area == req_area);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hit   <= 1'b0;
      found <= '0;
    end else if (en && take) begin
      hit <= 1'b1;
      if (locate) begin
        found <= area;
      end
    end
  end

endmodule

// ----- rtl/core/ip_range_area_classifier.sv -----
// ----------------------------------------------------------------------------
// ip_range_area_classifier
// Sequence: add and unused request words go from accept to the done state,
//   then to the output register; locate and check first walk every stored
//   entry through the table read and scan accumulator, unless it is empty.
//   One word at a time; the next waits until the response loads, not held.
// Reset: clears the entry count and control; the table itself is not cleared.
// ----------------------------------------------------------------------------
module ip_range_area_classifier import ipr_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int AREA_BITS = AREA_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [1:0]             req_type,
  input  logic [ADDR_W-1:0]      ip_addr,
  input  logic [ADDR_W-1:0]      range_low,
  input  logic [ADDR_W-1:0]      range_high,
  input  logic [AREA_PORT_W-1:0] area_code,
  // response channel
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic                   hit,
  output logic [AREA_PORT_W-1:0] found_area,
  output logic                   status
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  state_t state, state_next;

  // Sequencer and request registers
  logic [CW-1:0]        count;
  logic [CW-1:0]        issue_idx;
  logic                 rd_vld;
  logic                 locate;
  logic [ADDR_W-1:0]    addr;
  logic [AREA_BITS-1:0] area;
  logic                 full_flag;

  logic                 accept;
  logic                 is_lookup;
  logic                 is_add;
  logic                 table_full;
  logic                 wr_en;
  logic                 rd_en;
  logic                 load_out;
  logic                 scan_over;
  logic [AREA_BITS-1:0] area_in;

  bounds_t              wr_bounds;
  bounds_t              rd_bounds;
  logic [AREA_BITS-1:0] rd_area;
  logic                 sc_hit;
  logic [AREA_BITS-1:0] sc_found;
  logic [AREA_PORT_W-1:0] sc_found_w;

  assign accept     = req_valid && !req_stall;
  assign is_lookup  = (req_type == REQ_LOCATE) || (req_type == REQ_CHECK);
  assign is_add     = (req_type == REQ_ADD);
  assign table_full = (count == FULL_CNT);
  assign wr_en      = accept && is_add && !table_full;
  assign scan_over  = (issue_idx == count) && !rd_vld;

  assign wr_bounds.low  = range_low;
  assign wr_bounds.high = range_high;

  // Fit the area code to the stored width: keep the low bits, zero-extend
  // when the store is wider than the port.
  for (genvar gi = 0; gi < AREA_BITS; gi++) begin : g_area_in
    if (gi < AREA_PORT_W) begin : g_bit
      assign area_in[gi] = area_code[gi];
    end else begin : g_zero
      assign area_in[gi] = 1'b0;
    end
  end

  for (genvar go = 0; go < AREA_PORT_W; go++) begin : g_area_out
    if (go < AREA_BITS) begin : g_bit
      assign sc_found_w[go] = sc_found[go];
    end else begin : g_zero
      assign sc_found_w[go] = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (is_lookup && (count != '0)) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_over) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_stall = 1'b1;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
      end
      S_SCAN: begin
        rd_en = (issue_idx != count);
      end
      S_DONE: begin
        load_out = !rsp_valid || !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issue_idx <= '0;
      rd_vld    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (wr_en) begin
        count <= count + 1'b1;
      end
      // restart the walk on every new request word, advance per read
      if (accept) begin
        issue_idx <= '0;
      end else if (rd_en) begin
        issue_idx <= issue_idx + 1'b1;
      end
    end
  end

  // Hold the request word for the walk
  always_ff @(posedge clk) begin
    if (accept) begin
      locate    <= (req_type == REQ_LOCATE);
      addr      <= ip_addr;
      area      <= area_in;
      full_flag <= is_add && table_full;
    end
  end

  ipr_table #(
    .ENTRIES   (ENTRIES),
    .AREA_BITS (AREA_BITS),
    .IW        (IW)
  ) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (count[IW-1:0]),
    .wr_bounds (wr_bounds),
    .wr_area   (area_in),
    .rd_en     (rd_en),
    .rd_addr   (issue_idx[IW-1:0]),
    .rd_bounds (rd_bounds),
    .rd_area   (rd_area)
  );

  ipr_scan #(
    .AREA_BITS (AREA_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .clear    (accept),
    .en       (rd_vld),
    .locate   (locate),
    .addr     (addr),
    .req_area (area),
    .bounds   (rd_bounds),
    .area     (rd_area),
    .hit      (sc_hit),
    .found    (sc_found)
  );

  // Output register: the accumulator was cleared at accept, so add and
  // unused request words come out as a miss with area zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit        <= sc_hit;
      found_area <= sc_found_w;
      status     <= full_flag;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond table depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count != FULL_CNT))
    else $error("write into full table");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (count == $past(count) + 1'b1))
    else $error("entry count did not advance on add");

  a_read_follow: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> rd_vld)
    else $error("read data not tagged valid");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> rsp_valid)
    else $error("response word lost");

endmodule

// ----- test/ip_range_area_classifier_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_range_area_classifier_checker
// Watches the request and response channels of the range classifier. Keeps
// its own copy of the range table and works out each expected response word.
// It then compares every response word field by field, in order.
// ----------------------------------------------------------------------------
module ip_range_area_classifier_checker import ipr_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int AREA_BITS = AREA_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_stall,
  input  logic [1:0]             req_type,
  input  logic [ADDR_W-1:0]      ip_addr,
  input  logic [ADDR_W-1:0]      range_low,
  input  logic [ADDR_W-1:0]      range_high,
  input  logic [AREA_PORT_W-1:0] area_code,
  input  logic                   rsp_valid,
  input  logic                   rsp_stall,
  input  logic                   hit,
  input  logic [AREA_PORT_W-1:0] found_area,
  input  logic                   status,
  output int                     fail_count,
  output int                     words_due,
  output int                     results_seen
);

  localparam logic [AREA_PORT_W-1:0] AREA_MASK = AREA_PORT_W'((1 << AREA_BITS) - 1);
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic                   hit;
    logic [AREA_PORT_W-1:0] area;
    logic                   full;
  } answer_t;

  logic [ADDR_W-1:0]      low_tbl  [ENTRIES];
  logic [ADDR_W-1:0]      high_tbl [ENTRIES];
  logic [AREA_PORT_W-1:0] area_tbl [ENTRIES];
  int                     fill = 0;
  answer_t                answers_due [$];
  int                     errors = 0;
  int                     seen = 0;

  // Apply one request word to the table copy and return its response word.
  function automatic answer_t classify_word(input logic [1:0] kind,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [ADDR_W-1:0] lo,
                                            input logic [ADDR_W-1:0] hi,
                                            input logic [AREA_PORT_W-1:0] area_in);
    answer_t                ans;
    logic [AREA_PORT_W-1:0] area;
    ans  = '0;
    area = area_in & AREA_MASK;
    case (kind)
      REQ_ADD: begin
        if (fill < ENTRIES) begin
          low_tbl[fill]  = lo;
          high_tbl[fill] = hi;
          area_tbl[fill] = area;
          fill++;
        end else begin
          ans.full = 1'b1;
        end
      end
      REQ_LOCATE: begin
        for (int i = 0; i < fill; i++) begin
          if (addr >= low_tbl[i] && addr <= high_tbl[i] &&
              (!ans.hit || area_tbl[i] < ans.area)) begin
            ans.hit  = 1'b1;
            ans.area = area_tbl[i];
          end
        end
      end
      REQ_CHECK: begin
        for (int i = 0; i < fill; i++) begin
          if (area_tbl[i] == area && addr >= low_tbl[i] && addr <= high_tbl[i])
            ans.hit = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (rst) begin
      fill = 0;
      answers_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        got = {hit, found_area, status};
        seen++;
        if (answers_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected response word: hit %0b area %0h status %0b",
                     $time, got.hit, got.area, got.full);
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: expected %0b/%0h/%0b, got %0b/%0h/%0b (hit/area/status)",
                       $time, want.hit, want.area, want.full,
                       got.hit, got.area, got.full);
          end
        end
      end
      // Append the expected word at the tail of the queue.
      if (req_valid && !req_stall)
        answers_due = {answers_due,
                       classify_word(req_type, ip_addr, range_low, range_high,
                                     area_code)};
    end
    fail_count   <= errors;
    words_due    <= answers_due.size();
    results_seen <= seen;
  end

endmodule

// ----- test/ip_range_area_classifier_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_range_area_classifier_tb
// Drives add, locate, check and unused request words into the range
// classifier. A directed opening covers bounds, inverted and duplicate
// ranges, followed by a random mix that fills the table past full. The
// checker beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module ip_range_area_classifier_tb;
  import ipr_pkg::*;

  // Request code the block does not define; it must answer with all zeros.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_WORDS  = 1725;
  localparam int IDLE_PCT      = 34;
  localparam int QUIET_LIMIT   = 4000;           // cycles with no word moving
  localparam int SETTLE_CYCLES = ENTRIES_DEF + 8; // longest lookup plus margin

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_stall;
  logic [1:0]             req_type;
  logic [ADDR_W-1:0]      ip_addr;
  logic [ADDR_W-1:0]      range_low;
  logic [ADDR_W-1:0]      range_high;
  logic [AREA_PORT_W-1:0] area_code;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  logic                   hit;
  logic [AREA_PORT_W-1:0] found_area;
  logic                   status;

  int fail_count;
  int words_due;
  int results_seen;

  // Idling switch shared by both sides; cleared for one long clean stretch.
  logic idle_on = 1'b1;

  // Copy of what was added, used only to aim lookups at stored bounds.
  logic [ADDR_W-1:0]      aim_lo   [ENTRIES_DEF];
  logic [ADDR_W-1:0]      aim_hi   [ENTRIES_DEF];
  logic [AREA_PORT_W-1:0] aim_area [ENTRIES_DEF];
  int aim_n = 0;

  int n_add = 0, n_refused = 0, n_locate = 0, n_check = 0, n_unused = 0;

  ip_range_area_classifier dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .ip_addr    (ip_addr),
    .range_low  (range_low),
    .range_high (range_high),
    .area_code  (area_code),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .hit        (hit),
    .found_area (found_area),
    .status     (status)
  );

  ip_range_area_classifier_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .ip_addr      (ip_addr),
    .range_low    (range_low),
    .range_high   (range_high),
    .area_code    (area_code),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .hit          (hit),
    .found_area   (found_area),
    .status       (status),
    .fail_count   (fail_count),
    .words_due    (words_due),
    .results_seen (results_seen)
  );

  // 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Stall the response side at random; change only on the falling edge.
  always @(negedge clk) begin
    rsp_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Present one request word at the falling edge and hold it until accepted.
  // Entered and left just after a falling edge; valid stays high on return.
  task automatic send_word(input logic [1:0]             kind,
                           input logic [ADDR_W-1:0]      addr,
                           input logic [ADDR_W-1:0]      lo,
                           input logic [ADDR_W-1:0]      hi,
                           input logic [AREA_PORT_W-1:0] area);
    // Idle a random number of cycles before the word.
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_type   = kind;
    ip_addr    = addr;
    range_low  = lo;
    range_high = hi;
    area_code  = area;
    req_valid  = 1'b1;
    // Wait for the edge that takes the word.
    do @(posedge clk); while (req_stall !== 1'b0);
    @(negedge clk);
    case (kind)
      REQ_ADD: begin
        n_add++;
        if (aim_n < ENTRIES_DEF) begin
          aim_lo[aim_n]   = lo;
          aim_hi[aim_n]   = hi;
          aim_area[aim_n] = area;
          aim_n++;
        end else begin
          n_refused++;
        end
      end
      REQ_LOCATE: n_locate++;
      REQ_CHECK:  n_check++;
      default:    n_unused++;
    endcase
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0]      lo;
    logic [ADDR_W-1:0]      hi;
    logic [ADDR_W-1:0]      addr;
    logic [AREA_PORT_W-1:0] area;
    logic [ADDR_W:0]        wide;
    int                     pick;
    int                     shape;
    int                     j;

    // Hold every input at a known value from time zero.
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_type   = REQ_ADD;
    ip_addr    = '0;
    range_low  = '0;
    range_high = '0;
    area_code  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening: lookups on an empty table and the unused code first.
    send_word(REQ_LOCATE, 32'h0000_0000, '0, '0, 8'h00);
    send_word(REQ_CHECK,  32'hFFFF_FFFF, '0, '0, 8'hFF);
    send_word(REQ_UNUSED, '1, '1, '1, '1);
    // Plain, single-point, inverted, edge-of-space, duplicate and wide ranges.
    send_word(REQ_ADD, '0, 32'd10, 32'd20, 8'd5);
    send_word(REQ_ADD, '0, 32'd15, 32'd15, 8'd3);
    send_word(REQ_ADD, '0, 32'd100, 32'd50, 8'd0);
    send_word(REQ_ADD, '0, 32'h0000_0000, 32'h0000_0000, 8'd200);
    send_word(REQ_ADD, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
    send_word(REQ_ADD, '0, 32'd10, 32'd20, 8'd5);
    send_word(REQ_ADD, '0, 32'h8000_0000, 32'hBFFF_FFFF, 8'd1);
    // Locate: both ends of the address space, overlap resolved by lowest area.
    send_word(REQ_LOCATE, 32'h0000_0000, '0, '0, 8'h00);
    send_word(REQ_LOCATE, 32'hFFFF_FFFF, '0, '0, 8'h00);
    send_word(REQ_LOCATE, 32'd15, '0, '0, 8'h00);
    send_word(REQ_LOCATE, 32'd10, '0, '0, 8'h00);
    send_word(REQ_LOCATE, 32'd21, '0, '0, 8'h00);
    send_word(REQ_LOCATE, 32'd75, '0, '0, 8'h00);
    send_word(REQ_LOCATE, 32'hBFFF_FFFF, '0, '0, 8'h00);
    // Check: inverted range never holds, single point, wrong area, edges.
    send_word(REQ_CHECK, 32'd75, '0, '0, 8'd0);
    send_word(REQ_CHECK, 32'd15, '0, '0, 8'd3);
    send_word(REQ_CHECK, 32'd16, '0, '0, 8'd3);
    send_word(REQ_CHECK, 32'd9, '0, '0, 8'd5);
    send_word(REQ_CHECK, 32'hFFFF_FFFF, '0, '0, 8'd255);
    send_word(REQ_CHECK, 32'h0000_0000, '0, '0, 8'd200);
    send_word(REQ_UNUSED, '0, '0, '0, '0);

    // Random mix. Adds are sparse so the table fills about halfway through,
    // leaving lookups over every table size and refused adds once full.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      idle_on = !(n >= RANDOM_WORDS * 2 / 5 && n < RANDOM_WORDS * 3 / 5);
      pick    = $urandom_range(0, 99);
      if (pick < 6) begin
        shape = $urandom_range(0, 99);
        lo    = $urandom;
        if (shape < 6) begin
          hi = lo - ADDR_W'($urandom_range(1, 5000));
        end else if (shape < 14) begin
          hi = lo;
        end else begin
          // Mostly narrow spans; a few wide ones. Clip at the top address.
          wide = {1'b0, lo} + ((shape < 20) ? (ADDR_W + 1)'($urandom_range(0, 32'h0FFF_FFFF))
                                            : (ADDR_W + 1)'($urandom_range(0, 4095)));
          hi   = wide[ADDR_W] ? '1 : wide[ADDR_W-1:0];
        end
        // Small area pool so overlapping ranges compete on the lowest area.
        shape = $urandom_range(0, 99);
        if (shape < 70)
          area = AREA_PORT_W'($urandom_range(0, 7));
        else if (shape < 80)
          area = {AREA_PORT_W{shape[0]}};
        else
          area = AREA_PORT_W'($urandom_range(0, 255));
        send_word(REQ_ADD, $urandom, lo, hi, area);
      end else if (pick < 8) begin
        send_word(REQ_UNUSED, $urandom, $urandom, $urandom, AREA_PORT_W'($urandom_range(0, 255)));
      end else begin
        // Aim most lookups at stored bounds and their neighbors.
        addr  = $urandom;
        area  = AREA_PORT_W'($urandom_range(0, 255));
        shape = $urandom_range(0, 99);
        if (aim_n != 0 && shape >= 25) begin
          j = $urandom_range(0, aim_n - 1);
          case (shape % 5)
            0: addr = aim_lo[j];
            1: addr = aim_hi[j];
            2: addr = aim_lo[j] - 1;
            3: addr = aim_hi[j] + 1;
            default: begin
              addr = aim_lo[j];
              if (aim_hi[j] > aim_lo[j]) begin
                wide = {1'b0, aim_hi[j]} - {1'b0, aim_lo[j]} + 1;
                addr = aim_lo[j] + ADDR_W'({1'b0, $urandom} % wide);
              end
            end
          endcase
          if ($urandom_range(0, 99) < 60)
            area = aim_area[j];
          else
            area = AREA_PORT_W'($urandom_range(0, 7));
        end
        send_word((pick < 54) ? REQ_LOCATE : REQ_CHECK, addr, $urandom, $urandom, area);
      end
    end
    req_valid = 1'b0;
    idle_on   = 1'b1;

    // Drain outstanding responses, then watch for stray words a while longer.
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d adds (%0d refused on a full table), %0d locates, %0d checks, %0d unused words;",
             n_add, n_refused, n_locate, n_check, n_unused);
    $display("compared %0d response words, %0d failures.", results_seen, fail_count);
    if (fail_count == 0 && words_due == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ipr_pkg.sv
rtl/core/ipr_table.sv
rtl/core/ipr_scan.sv
rtl/core/ip_range_area_classifier.sv
test/ip_range_area_classifier_checker.sv
test/ip_range_area_classifier_tb.sv
